// ----- rtl/stl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stl_pkg - shared types and tables for the script token lexer
// Token kind codes, scan states, result item and burst structs, keyword table.
// ----------------------------------------------------------------------------
package stl_pkg;

    localparam int KW_MAX_LEN  = 7;   // identifier bytes held back while a keyword is possible
    localparam int KW_TEXT_LEN = 7;   // longest keyword in the table
    localparam int NUM_KW      = 16;
    localparam int TAIL_MAX    = 3;

    localparam int LEN_W  = $clog2(KW_MAX_LEN + 1);
    localparam int CNT_W  = $clog2(KW_MAX_LEN + 2);
    localparam int IDX_W  = $clog2(KW_MAX_LEN);
    localparam int TAIL_W = $clog2(TAIL_MAX + 1);
    localparam int TOT_W  = $clog2(KW_MAX_LEN + TAIL_MAX + 1);

    localparam logic [5:0] K_EOF    = 6'd0;
    localparam logic [5:0] K_IDENT  = 6'd17;
    localparam logic [5:0] K_NUMBER = 6'd18;
    localparam logic [5:0] K_GE     = 6'd20;
    localparam logic [5:0] K_LE     = 6'd21;
    localparam logic [5:0] K_EQ     = 6'd22;
    localparam logic [5:0] K_GT     = 6'd23;
    localparam logic [5:0] K_LT     = 6'd24;
    localparam logic [5:0] K_COLON  = 6'd25;
    localparam logic [5:0] K_PLUS   = 6'd26;
    localparam logic [5:0] K_MINUS  = 6'd27;
    localparam logic [5:0] K_STAR   = 6'd28;
    localparam logic [5:0] K_SLASH  = 6'd29;
    localparam logic [5:0] K_QUEST  = 6'd30;
    localparam logic [5:0] K_STRING = 6'd31;
    localparam logic [5:0] K_ERROR  = 6'd32;
    localparam logic [5:0] K_CHAR   = 6'd33;

    typedef enum logic [9:0] {
        M_IDLE   = 10'b00_0000_0001,
        M_HELD   = 10'b00_0000_0010,
        M_STREAM = 10'b00_0000_0100,
        M_NUMBER = 10'b00_0000_1000,
        M_STRING = 10'b00_0001_0000,
        M_BANG   = 10'b00_0010_0000,
        M_LINE   = 10'b00_0100_0000,
        M_BLOCK  = 10'b00_1000_0000,
        M_GT     = 10'b01_0000_0000,
        M_LT     = 10'b10_0000_0000
    } mode_t;

    typedef struct packed {
        logic [5:0] kind;
        logic [7:0] ch;
    } item_t;

    // results of one input byte: held chars first, then the tail items
    typedef struct packed {
        logic [KW_MAX_LEN-1:0][7:0] chars;
        logic [CNT_W-1:0]           flush_n;
        item_t [TAIL_MAX-1:0]       tail;
        logic [TAIL_W-1:0]          tail_n;
    } burst_t;

    function automatic item_t mk_item(input logic [5:0] kind, input logic [7:0] ch);
        item_t it;
        it.kind = kind;
        it.ch   = ch;
        return it;
    endfunction

    // keyword text, first char in the top byte, zero padded
    function automatic logic [KW_TEXT_LEN*8-1:0] kw_word(input logic [3:0] k);
        logic [KW_TEXT_LEN*8-1:0] w;
        case (k)
            4'd0:    w = "display";
            4'd1:    w = {"prompt", 8'd0};
            4'd2:    w = {"true", 24'd0};
            4'd3:    w = {"false", 16'd0};
            4'd4:    w = {"loop", 24'd0};
            4'd5:    w = "iterate";
            4'd6:    w = {"from", 24'd0};
            4'd7:    w = {"to", 40'd0};
            4'd8:    w = {"if", 40'd0};
            4'd9:    w = {"then", 24'd0};
            4'd10:   w = {"else", 24'd0};
            4'd11:   w = {"while", 16'd0};
            4'd12:   w = {"until", 16'd0};
            4'd13:   w = {"throw", 16'd0};
            4'd14:   w = {"inject", 8'd0};
            4'd15:   w = {"alias", 16'd0};
            default: w = '0;
        endcase
        return w;
    endfunction

    function automatic logic [CNT_W-1:0] kw_len(input logic [3:0] k);
        logic [CNT_W-1:0] n;
        case (k)
            4'd0, 4'd5:                        n = CNT_W'(7);
            4'd1, 4'd14:                       n = CNT_W'(6);
            4'd3, 4'd11, 4'd12, 4'd13, 4'd15:  n = CNT_W'(5);
            4'd2, 4'd4, 4'd6, 4'd9, 4'd10:     n = CNT_W'(4);
            default:                           n = CNT_W'(2);
        endcase
        return n;
    endfunction

    function automatic logic [7:0] kw_char(input logic [3:0] k, input int i);
        logic [KW_TEXT_LEN*8-1:0] w;
        logic [7:0] c;
        w = kw_word(k);
        c = 8'd0;
        if (i < KW_TEXT_LEN)
            c = w[(KW_TEXT_LEN-1-i)*8 +: 8];
        return c;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/script_token_lexer_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// script_token_lexer_core - streaming lexer for a small script language
// Takes source bytes and returns value chars and token kinds, one per beat.
//
//   channel  signals                                   dir  beats
//   text     text_valid/text_ready, text_byte          in   one source byte
//   token    token_valid/token_ready, token_kind,      out  one result
//            value_char, last_of_run
//
// A byte is scanned in the cycle it is taken; its results (0 to 10) are
// registered and leave one per cycle while token_ready is high, from the next cycle on.
// A byte with at most one result keeps a one byte per cycle stream while
// token_ready is high; a byte with more results holds off the next byte until its burst drains.
// The next byte is taken in the cycle the last result of a burst goes out.
// Reset puts the scanner in idle with no held identifier bytes.
// ----------------------------------------------------------------------------
module script_token_lexer_core
    import stl_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       text_valid,
    output logic            text_ready,
    input  wire logic [7:0] text_byte,
    output logic            token_valid,
    input  wire logic       token_ready,
    output logic [5:0]      token_kind,
    output logic [7:0]      value_char,
    output logic            last_of_run
);

    burst_t            scan_burst;
    burst_t            burst_reg;
    logic [TOT_W-1:0]  new_total;
    logic [TOT_W-1:0]  total_reg;
    logic [TOT_W-1:0]  pos_reg;
    logic              busy_reg;
    logic              pos_last;
    logic              text_take;
    logic              token_take;
    logic              in_flush;
    logic [TAIL_W-1:0] tail_idx;
    item_t             cur;

    stl_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (text_take),
        .text_byte (text_byte),
        .burst     (scan_burst)
    );

    assign new_total  = TOT_W'(scan_burst.flush_n) + TOT_W'(scan_burst.tail_n);
    assign pos_last   = pos_reg == total_reg - TOT_W'(1);
    assign text_ready = !busy_reg || (token_ready && pos_last);
    assign text_take  = text_valid && text_ready;
    assign token_take = busy_reg && token_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            pos_reg   <= '0;
            total_reg <= '0;
        end
        else if (text_take)
        begin
            busy_reg  <= new_total != '0;
            pos_reg   <= '0;
            total_reg <= new_total;
        end
        else if (token_take)
        begin
            if (pos_last)
                busy_reg <= 1'b0;
            else
                pos_reg <= pos_reg + TOT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_take)
            burst_reg <= scan_burst;
    end

    // held chars go out first, then the tail items
    assign in_flush = pos_reg < TOT_W'(burst_reg.flush_n);
    assign tail_idx = TAIL_W'(pos_reg - TOT_W'(burst_reg.flush_n));

    always_comb
    begin
        if (in_flush)
            cur = mk_item(K_CHAR, burst_reg.chars[pos_reg[IDX_W-1:0]]);
        else
            cur = burst_reg.tail[tail_idx];
    end

    assign token_valid = busy_reg;
    assign token_kind  = cur.kind;
    assign value_char  = cur.ch;
    assign last_of_run = pos_last;

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> pos_reg < total_reg)
        else $error("burst position past end of burst");

    a_burst_starts: assert property (@(posedge clk) disable iff (!rst_n)
        text_take && new_total != '0 |=> token_valid && pos_reg == '0)
        else $error("results of a taken byte did not start");

    a_char_only_on_char: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_kind != K_CHAR |-> value_char == 8'd0)
        else $error("value char set on a kind result");

    a_no_take_mid_burst: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && !last_of_run |-> !text_ready)
        else $error("byte taken before burst drained");

endmodule
`default_nettype wire

// ----- rtl/stl_scan.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stl_scan - lexer state and per-byte scan logic
// Holds the scan state and held identifier bytes, and works out the full
// burst of results for one accepted byte combinationally.
// ----------------------------------------------------------------------------
module stl_scan
    import stl_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] text_byte,
    output burst_t          burst
);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_USCORE = 8'h5F;

    mode_t                      mode_reg, mode_next;
    logic [LEN_W-1:0]           len_reg, len_next;
    logic                       bang_reg, bang_next;
    logic [KW_MAX_LEN-1:0][7:0] held_reg;

    logic is_alpha, is_digit, is_space, ident_char, ident_start;
    logic hold_ident;
    logic [LEN_W-1:0]           len_eff;
    logic [CNT_W-1:0]           cand_len;
    logic [KW_MAX_LEN-1:0][7:0] cand;
    logic                       could_be, prefix_ok;
    logic                       kw_hit, exact_ok;
    logic [5:0]                 kw_kind;

    item_t [1:0]       idle_item;
    logic [1:0]        idle_n;
    mode_t             idle_mode;
    logic [LEN_W-1:0]  idle_len;

    logic              run_idle, pre_v;
    item_t             pre;
    logic [CNT_W-1:0]  flush_n;
    logic [1:0]        idle_n_eff;

    assign is_alpha    = (text_byte >= "a" && text_byte <= "z") ||
                         (text_byte >= "A" && text_byte <= "Z");
    assign is_digit    = text_byte >= "0" && text_byte <= "9";
    assign is_space    = text_byte == CH_SPACE || (text_byte >= CH_TAB && text_byte <= CH_CR);
    assign ident_start = is_alpha || text_byte == CH_USCORE;
    assign ident_char  = ident_start || is_digit;
    assign hold_ident  = mode_reg == M_HELD && ident_char;

    // candidate prefix: held bytes with this byte appended (or this byte alone)
    assign len_eff  = hold_ident ? len_reg : '0;
    assign cand_len = CNT_W'(len_eff) + CNT_W'(1);

    always_comb
    begin
        for (int i = 0; i < KW_MAX_LEN; i++)
        begin
            cand[i] = (LEN_W'(i) == len_eff) ? text_byte : held_reg[i];
        end
    end

    always_comb
    begin
        could_be = 1'b0;
        for (int k = 0; k < NUM_KW; k++)
        begin
            prefix_ok = kw_len(4'(k)) >= cand_len;
            for (int i = 0; i < KW_MAX_LEN; i++)
            begin
                if (CNT_W'(i) < cand_len && cand[i] != kw_char(4'(k), i))
                    prefix_ok = 1'b0;
            end
            if (prefix_ok)
                could_be = 1'b1;
        end
    end

    always_comb
    begin
        kw_hit  = 1'b0;
        kw_kind = K_IDENT;
        for (int k = 0; k < NUM_KW; k++)
        begin
            exact_ok = kw_len(4'(k)) == CNT_W'(len_reg);
            for (int i = 0; i < KW_MAX_LEN; i++)
            begin
                if (CNT_W'(i) < CNT_W'(len_reg) && held_reg[i] != kw_char(4'(k), i))
                    exact_ok = 1'b0;
            end
            if (exact_ok)
            begin
                kw_hit  = 1'b1;
                kw_kind = 6'(k + 1);
            end
        end
    end

    // fresh scan of a byte from the idle state
    always_comb
    begin
        idle_item[0] = mk_item(K_CHAR, text_byte);
        idle_item[1] = mk_item(K_ERROR, 8'd0);
        idle_n       = 2'd0;
        idle_mode    = M_IDLE;
        idle_len     = '0;
        if (text_byte == CH_NUL)
        begin
            idle_item[0] = mk_item(K_EOF, 8'd0);
            idle_n       = 2'd1;
        end
        else if (is_space)
        begin
            idle_n = 2'd0;
        end
        else if (ident_start)
        begin
            if (could_be)
            begin
                idle_mode = M_HELD;
                idle_len  = LEN_W'(1);
            end
            else
            begin
                idle_n    = 2'd1;
                idle_mode = M_STREAM;
            end
        end
        else if (is_digit)
        begin
            idle_n    = 2'd1;
            idle_mode = M_NUMBER;
        end
        else
        begin
            case (text_byte)
                CH_BANG:  idle_mode = M_BANG;
                CH_GT:    idle_mode = M_GT;
                CH_LT:    idle_mode = M_LT;
                CH_QUOTE: idle_mode = M_STRING;
                CH_EQ:    begin idle_item[0] = mk_item(K_EQ, 8'd0);    idle_n = 2'd1; end
                CH_COLON: begin idle_item[0] = mk_item(K_COLON, 8'd0); idle_n = 2'd1; end
                CH_PLUS:  begin idle_item[0] = mk_item(K_PLUS, 8'd0);  idle_n = 2'd1; end
                CH_MINUS: begin idle_item[0] = mk_item(K_MINUS, 8'd0); idle_n = 2'd1; end
                CH_STAR:  begin idle_item[0] = mk_item(K_STAR, 8'd0);  idle_n = 2'd1; end
                CH_SLASH: begin idle_item[0] = mk_item(K_SLASH, 8'd0); idle_n = 2'd1; end
                CH_QUEST: begin idle_item[0] = mk_item(K_QUEST, 8'd0); idle_n = 2'd1; end
                default:  idle_n = 2'd2;
            endcase
        end
    end

    always_comb
    begin
        mode_next = mode_reg;
        len_next  = len_reg;
        bang_next = bang_reg;
        flush_n   = '0;
        pre_v     = 1'b0;
        pre       = mk_item(K_CHAR, text_byte);
        run_idle  = 1'b0;
        unique case (mode_reg)
            M_HELD:
            begin
                if (ident_char)
                begin
                    if (len_reg < LEN_W'(KW_MAX_LEN))
                    begin
                        if (could_be)
                            len_next = len_reg + LEN_W'(1);
                        else
                        begin
                            flush_n   = cand_len;
                            mode_next = M_STREAM;
                            len_next  = '0;
                        end
                    end
                    else
                    begin
                        // too long for a keyword: release all held bytes plus this one
                        flush_n   = CNT_W'(KW_MAX_LEN);
                        pre_v     = 1'b1;
                        mode_next = M_STREAM;
                        len_next  = '0;
                    end
                end
                else
                begin
                    if (kw_hit)
                        pre = mk_item(kw_kind, 8'd0);
                    else
                    begin
                        flush_n = CNT_W'(len_reg);
                        pre     = mk_item(K_IDENT, 8'd0);
                    end
                    pre_v    = 1'b1;
                    run_idle = 1'b1;
                end
            end
            M_STREAM:
            begin
                pre_v = 1'b1;
                if (!ident_char)
                begin
                    pre      = mk_item(K_IDENT, 8'd0);
                    run_idle = 1'b1;
                end
            end
            M_NUMBER:
            begin
                pre_v = 1'b1;
                if (!is_digit)
                begin
                    pre      = mk_item(K_NUMBER, 8'd0);
                    run_idle = 1'b1;
                end
            end
            M_STRING:
            begin
                pre_v = 1'b1;
                if (text_byte == CH_QUOTE)
                begin
                    pre       = mk_item(K_STRING, 8'd0);
                    mode_next = M_IDLE;
                end
                else if (text_byte == CH_NUL)
                begin
                    // close the string, then the idle scan gives eof
                    pre      = mk_item(K_STRING, 8'd0);
                    run_idle = 1'b1;
                end
            end
            M_BANG:
            begin
                if (text_byte == CH_BANG)
                begin
                    bang_next = 1'b0;
                    mode_next = M_BLOCK;
                end
                else if (text_byte == CH_NL)
                    mode_next = M_IDLE;
                else if (text_byte == CH_NUL)
                    run_idle = 1'b1;
                else
                    mode_next = M_LINE;
            end
            M_LINE:
            begin
                if (text_byte == CH_NL)
                    mode_next = M_IDLE;
                else if (text_byte == CH_NUL)
                    run_idle = 1'b1;
            end
            M_BLOCK:
            begin
                if (text_byte == CH_NUL)
                begin
                    bang_next = 1'b0;
                    run_idle  = 1'b1;
                end
                else if (text_byte == CH_BANG)
                begin
                    if (bang_reg)
                    begin
                        bang_next = 1'b0;
                        mode_next = M_IDLE;
                    end
                    else
                        bang_next = 1'b1;
                end
                else
                    bang_next = 1'b0;
            end
            M_GT:
            begin
                pre_v = 1'b1;
                if (text_byte == CH_EQ)
                begin
                    pre       = mk_item(K_GE, 8'd0);
                    mode_next = M_IDLE;
                end
                else
                begin
                    pre      = mk_item(K_GT, 8'd0);
                    run_idle = 1'b1;
                end
            end
            M_LT:
            begin
                pre_v = 1'b1;
                if (text_byte == CH_EQ)
                begin
                    pre       = mk_item(K_LE, 8'd0);
                    mode_next = M_IDLE;
                end
                else
                begin
                    pre      = mk_item(K_LT, 8'd0);
                    run_idle = 1'b1;
                end
            end
            default:
                run_idle = 1'b1;
        endcase
        if (run_idle)
        begin
            mode_next = idle_mode;
            len_next  = idle_len;
        end
    end

    assign idle_n_eff = run_idle ? idle_n : 2'd0;

    always_comb
    begin
        burst.chars   = hold_ident ? cand : held_reg;
        burst.flush_n = flush_n;
        burst.tail_n  = TAIL_W'(pre_v) + TAIL_W'(idle_n_eff);
        if (pre_v)
        begin
            burst.tail[0] = pre;
            burst.tail[1] = idle_item[0];
            burst.tail[2] = idle_item[1];
        end
        else
        begin
            burst.tail[0] = idle_item[0];
            burst.tail[1] = idle_item[1];
            burst.tail[2] = idle_item[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            len_reg  <= '0;
            bang_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            len_reg  <= len_next;
            bang_reg <= bang_next;
        end
    end

    // only entries below the held length are ever read
    always_ff @(posedge clk)
    begin
        if (accept)
            held_reg <= cand;
    end

    a_len_zero_outside_held: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != M_HELD |-> len_reg == '0)
        else $error("held length nonzero outside held state");

    a_len_nonzero_in_held: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == M_HELD |-> len_reg != '0)
        else $error("held state with no held bytes");

    a_bang_only_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        accept && mode_reg != M_BLOCK |=> !bang_reg)
        else $error("block comment bang flag left set");

endmodule
`default_nettype wire

// ----- dv/script_token_lexer_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// script_token_lexer_core_test - self-checking bench for the script lexer
// Feeds source bytes over the text channel and predicts every token beat from
// a behavioral lexer kept in step with accepted bytes. Each token beat is
// checked field by field in order. Directed cases come first, among them one
// long receiver hold-off, then random text under several idle and stall mixes.
// ----------------------------------------------------------------------------
module script_token_lexer_core_test;
    import stl_pkg::*;

    typedef struct packed {
        logic [5:0] kind;
        logic [7:0] ch;
        logic       run_end;
    } lex_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       text_valid = 1'b0;
    logic       text_ready;
    logic [7:0] text_byte = 8'd0;
    logic       token_valid;
    logic       token_ready = 1'b0;
    logic [5:0] token_kind;
    logic [7:0] value_char;
    logic       last_of_run;

    string keyword_text [NUM_KW] = '{"display", "prompt", "true", "false", "loop",
        "iterate", "from", "to", "if", "then", "else", "while", "until", "throw",
        "inject", "alias"};
    string ident_charset =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    string symbol_set = "=:+-*/?><";

    // lexer state as the block should hold it
    mode_t       lex_mode = M_IDLE;
    logic [7:0]  held_chars [KW_MAX_LEN];
    int          held_len = 0;
    bit          block_bang = 1'b0;

    lex_result_t step_out [$];
    lex_result_t expected_tokens [$];
    lex_result_t want;
    logic [7:0]  pending_text [$];

    int error_count = 0;
    int taken_bytes = 0;
    int kw_turn = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;

    script_token_lexer_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_valid  (text_valid),
        .text_ready  (text_ready),
        .text_byte   (text_byte),
        .token_valid (token_valid),
        .token_ready (token_ready),
        .token_kind  (token_kind),
        .value_char  (value_char),
        .last_of_run (last_of_run)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // behavioral lexer
    // ------------------------------------------------------------------
    function automatic bit is_letter(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic bit is_digit(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit is_blank(logic [7:0] b);
        return b == " " || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic void emit_token(logic [5:0] kind, logic [7:0] ch);
        lex_result_t t;
        if (step_out.size() < 10)
        begin
            t.kind = kind;
            t.ch = ch;
            t.run_end = 1'b0;
            step_out.push_back(t);
        end
    endfunction

    // whole: held text equals keyword k, else held text is a prefix of it
    function automatic bit held_matches(int k, bit whole);
        bit same;
        same = whole ? (keyword_text[k].len() == held_len)
                     : (keyword_text[k].len() >= held_len);
        for (int i = 0; i < held_len; i++)
            if (keyword_text[k][i] != held_chars[i])
                same = 1'b0;
        return same;
    endfunction

    function automatic void release_held();
        for (int i = 0; i < held_len; i++)
            emit_token(K_CHAR, held_chars[i]);
        held_len = 0;
    endfunction

    function automatic void ident_push(logic [7:0] b);
        if (held_len < KW_MAX_LEN)
        begin
            held_chars[held_len] = b;
            held_len++;
            for (int k = 0; k < NUM_KW; k++)
                if (held_matches(k, 1'b0))
                begin
                    lex_mode = M_HELD;
                    return;
                end
            release_held();
        end
        else
        begin
            release_held();
            emit_token(K_CHAR, b);
        end
        lex_mode = M_STREAM;
    endfunction

    function automatic void finish_held();
        for (int k = 0; k < NUM_KW; k++)
            if (held_matches(k, 1'b1))
            begin
                emit_token(6'(k + 1), 8'd0);
                held_len = 0;
                return;
            end
        release_held();
        emit_token(K_IDENT, 8'd0);
    endfunction

    function automatic void scan_fresh(logic [7:0] b);
        lex_mode = M_IDLE;
        if (b == 8'd0)
            emit_token(K_EOF, 8'd0);
        else if (is_blank(b))
            return;
        else if (is_letter(b) || b == "_")
        begin
            held_len = 0;
            ident_push(b);
        end
        else if (is_digit(b))
        begin
            emit_token(K_CHAR, b);
            lex_mode = M_NUMBER;
        end
        else
            case (b)
                "!":     lex_mode = M_BANG;
                ">":     lex_mode = M_GT;
                "<":     lex_mode = M_LT;
                "\"":    lex_mode = M_STRING;
                "=":     emit_token(K_EQ, 8'd0);
                ":":     emit_token(K_COLON, 8'd0);
                "+":     emit_token(K_PLUS, 8'd0);
                "-":     emit_token(K_MINUS, 8'd0);
                "*":     emit_token(K_STAR, 8'd0);
                "/":     emit_token(K_SLASH, 8'd0);
                "?":     emit_token(K_QUEST, 8'd0);
                default:
                begin
                    emit_token(K_CHAR, b);
                    emit_token(K_ERROR, 8'd0);
                end
            endcase
    endfunction

    function automatic void predict_byte(logic [7:0] b);
        bit ident_byte;
        ident_byte = is_letter(b) || is_digit(b) || b == "_";
        step_out.delete();
        case (lex_mode)
            M_HELD:
                if (ident_byte)
                    ident_push(b);
                else
                begin
                    finish_held();
                    scan_fresh(b);
                end
            M_STREAM:
                if (ident_byte)
                    emit_token(K_CHAR, b);
                else
                begin
                    emit_token(K_IDENT, 8'd0);
                    scan_fresh(b);
                end
            M_NUMBER:
                if (is_digit(b))
                    emit_token(K_CHAR, b);
                else
                begin
                    emit_token(K_NUMBER, 8'd0);
                    scan_fresh(b);
                end
            M_STRING:
                if (b == "\"")
                begin
                    emit_token(K_STRING, 8'd0);
                    lex_mode = M_IDLE;
                end
                else if (b == 8'd0)
                begin
                    emit_token(K_STRING, 8'd0);
                    emit_token(K_EOF, 8'd0);
                    lex_mode = M_IDLE;
                end
                else
                    emit_token(K_CHAR, b);
            M_BANG:
                if (b == "!")
                begin
                    block_bang = 1'b0;
                    lex_mode = M_BLOCK;
                end
                else if (b == "\n")
                    lex_mode = M_IDLE;
                else if (b == 8'd0)
                begin
                    emit_token(K_EOF, 8'd0);
                    lex_mode = M_IDLE;
                end
                else
                    lex_mode = M_LINE;
            M_LINE:
                if (b == "\n")
                    lex_mode = M_IDLE;
                else if (b == 8'd0)
                begin
                    emit_token(K_EOF, 8'd0);
                    lex_mode = M_IDLE;
                end
            M_BLOCK:
                if (b == 8'd0)
                begin
                    emit_token(K_EOF, 8'd0);
                    block_bang = 1'b0;
                    lex_mode = M_IDLE;
                end
                else if (b == "!")
                begin
                    if (block_bang)
                    begin
                        block_bang = 1'b0;
                        lex_mode = M_IDLE;
                    end
                    else
                        block_bang = 1'b1;
                end
                else
                    block_bang = 1'b0;
            M_GT:
                if (b == "=")
                begin
                    emit_token(K_GE, 8'd0);
                    lex_mode = M_IDLE;
                end
                else
                begin
                    emit_token(K_GT, 8'd0);
                    scan_fresh(b);
                end
            M_LT:
                if (b == "=")
                begin
                    emit_token(K_LE, 8'd0);
                    lex_mode = M_IDLE;
                end
                else
                begin
                    emit_token(K_LT, 8'd0);
                    scan_fresh(b);
                end
            default:
                scan_fresh(b);
        endcase
        if (step_out.size() > 0)
            step_out[step_out.size() - 1].run_end = 1'b1;
        taken_bytes++;
        foreach (step_out[i])
            expected_tokens.push_back(step_out[i]);
    endfunction

    // ------------------------------------------------------------------
    // token check and byte prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (token_valid && token_ready)
            begin
                if (expected_tokens.size() == 0)
                begin
                    $display("%0t: token beat with nothing expected: kind %0d char %0d",
                             $time, token_kind, value_char);
                    error_count++;
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (token_kind !== want.kind)
                    begin
                        $display("%0t: token_kind expected %0d, actual %0d",
                                 $time, want.kind, token_kind);
                        error_count++;
                    end
                    if (value_char !== want.ch)
                    begin
                        $display("%0t: value_char expected %0d, actual %0d",
                                 $time, want.ch, value_char);
                        error_count++;
                    end
                    if (last_of_run !== want.run_end)
                    begin
                        $display("%0t: last_of_run expected %0d, actual %0d",
                                 $time, want.run_end, last_of_run);
                        error_count++;
                    end
                end
            end
            if (text_valid && text_ready)
                predict_byte(text_byte);
        end
    end

    // receiver: random stalls, plus long hold-offs on request
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            token_ready <= 1'b0;
        end
        else
            token_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic void add_byte(logic [7:0] b);
        pending_text.push_back(b);
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            pending_text.push_back(s[i]);
    endfunction

    function automatic logic [7:0] blank_byte();
        int n;
        n = $urandom_range(8, 13);
        return (n == 8) ? 8'd32 : 8'(n);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            text_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        text_valid <= 1'b1;
        text_byte <= b;
        do
            @(posedge clk);
        while (!text_ready);
    endtask

    task automatic send_pending();
        while (pending_text.size() != 0)
            send_byte(pending_text.pop_front());
    endtask

    task automatic wait_drained();
        text_valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic void add_random_token();
        int pick;
        int n;
        int k;
        logic [7:0] c;
        pick = $urandom_range(0, 19);
        if (pick < 5)
        begin
            // walk the keyword list so every keyword kind shows up
            add_text(keyword_text[kw_turn]);
            kw_turn = (kw_turn + 1) % NUM_KW;
            if ($urandom_range(0, 3) == 0)
                add_byte(ident_charset[$urandom_range(0, 62)]);
        end
        else if (pick == 5)
        begin
            k = $urandom_range(0, NUM_KW - 1);
            add_text(keyword_text[k].substr(0, $urandom_range(0, keyword_text[k].len() - 2)));
        end
        else if (pick < 8)
        begin
            n = $urandom_range(1, 12);
            add_byte(ident_charset[$urandom_range(0, 52)]);
            repeat (n - 1) add_byte(ident_charset[$urandom_range(0, 62)]);
        end
        else if (pick < 10)
            repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range("0", "9")));
        else if (pick == 10)
        begin
            add_byte("\"");
            repeat ($urandom_range(0, 6))
            begin
                c = 8'($urandom_range(1, 255));
                add_byte(c == "\"" ? 8'("#") : c);
            end
            add_byte($urandom_range(0, 7) == 0 ? 8'd0 : 8'("\""));
        end
        else if (pick < 14)
        begin
            c = symbol_set[$urandom_range(0, 8)];
            add_byte(c);
            if ((c == ">" || c == "<") && $urandom_range(0, 1))
                add_byte("=");
        end
        else if (pick == 14)
        begin
            add_byte("!");
            repeat ($urandom_range(0, 8))
            begin
                c = 8'($urandom_range(32, 126));
                add_byte(c == "!" ? 8'(".") : c);
            end
            add_byte($urandom_range(0, 7) == 0 ? 8'd0 : 8'("\n"));
        end
        else if (pick == 15)
        begin
            add_text("!!");
            repeat ($urandom_range(0, 8))
            begin
                if ($urandom_range(0, 4) == 0)
                    add_byte("!");
                add_byte($urandom_range(0, 3) == 0 ? blank_byte()
                                                   : ident_charset[$urandom_range(0, 62)]);
            end
            if ($urandom_range(0, 7) == 0)
                add_byte(8'd0);
            else
                add_text("!!");
        end
        else if (pick == 16)
            add_byte(8'($urandom_range(1, 255)));
        else if (pick == 17)
            add_byte(8'd0);
        else
            repeat ($urandom_range(1, 3)) add_byte(blank_byte());
        if ($urandom_range(0, 1))
            add_byte(blank_byte());
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_symbols();
        add_text(">=<=:+-*/?=x=");
        send_pending();
        wait_drained();
    endtask

    // lone compare symbols, then end of text inside a held identifier
    task automatic test_compare_lookahead();
        add_text("><a");
        add_byte(8'd0);
        send_pending();
        wait_drained();
    endtask

    // empty string, then a string cut off by end of text
    task automatic test_strings();
        add_text("\"\"\"q");
        add_byte(8'hff);
        add_byte(8'd0);
        send_pending();
        wait_drained();
    endtask

    // line comment, block comment, end of text in a comment, eof twice
    task automatic test_comments();
        add_text("!x\n!!a!!!");
        add_byte(8'd0);
        add_byte(8'd0);
        send_pending();
        wait_drained();
    endtask

    // keyword, over-long identifier, bad bytes, identifier cut by end of text
    task automatic test_identifiers();
        add_text("while displayx#");
        add_byte(8'h80);
        add_text("_9");
        add_byte(8'd0);
        send_pending();
        wait_drained();
    endtask

    // receiver holds off while long identifiers keep the input busy
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 400;
        repeat (4) add_text("iteratezq 9999 ");
        send_pending();
        wait_drained();
    endtask

    task automatic test_random_text(input int idle_pct, input int stall_pct,
                                    input int count);
        int goal;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        goal = taken_bytes + count;
        while (taken_bytes < goal)
        begin
            add_random_token();
            send_pending();
        end
        wait_drained();
    endtask

    initial
    begin
        send_idle_pct = 32;
        recv_stall_pct = 71;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_symbols();
        test_compare_lookahead();
        test_strings();
        test_comments();
        test_identifiers();
        test_backpressure();
        test_random_text(32, 71, 65);
        test_random_text(71, 32, 65);
        test_random_text(0, 0, 66);
        // flush whatever token is still pending
        add_byte(8'd0);
        send_pending();
        wait_drained();
        repeat (20) @(posedge clk);
        if (error_count == 0 && expected_tokens.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
